[src/amlc_pkg.sv]
// ----------------------------------------------------------------------------
// amlc_pkg: shared types and constants of the activity level classifier
// Field widths, register indexes, reset values and the control state type.
// ----------------------------------------------------------------------------
package amlc_pkg;

  localparam int FIELD_W    = 16;  // accelerometer field width on the channel
  localparam int COUNT_W    = 11;  // minute counters
  localparam int INDEX_W    = 32;  // sample index
  localparam int SUM_W      = 32;  // minute magnitude sum
  localparam int PHASE_W    = 16;  // samples within the minute
  localparam int VCOUNT_W   = 16;  // valid samples within the minute
  localparam int CUT_W      = 16;  // cut points, unsigned Q4.12
  localparam int FRAC_BITS  = 12;  // 1.0 g in Q3.12
  localparam int NUM_CUTS   = 3;
  localparam int STEP_W     = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_MINUTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTES_PER_BLOCK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_LIGHT          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_MODERATE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_VIGOROUS       = 3'd4;

  localparam logic [PHASE_W-1:0] RST_SAMPLES_PER_MINUTE = 16'd4800;
  localparam logic [COUNT_W-1:0] RST_MINUTES_PER_BLOCK  = 11'd1;
  localparam logic [CUT_W-1:0]   RST_CUT_LIGHT          = 16'd329;
  localparam logic [CUT_W-1:0]   RST_CUT_MODERATE       = 16'd463;
  localparam logic [CUT_W-1:0]   RST_CUT_VIGOROUS       = 16'd1545;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CLASSIFY,
    ST_TALLY,
    ST_EMIT
  } state_t;

endpackage

[src/amlc_in_if.sv]
// ----------------------------------------------------------------------------
// amlc_in_if: sample channel
// Valid/ready channel carrying one accelerometer sample or a flush command.
// ----------------------------------------------------------------------------
interface amlc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic signed [amlc_pkg::FIELD_W-1:0] accel_x;
  logic signed [amlc_pkg::FIELD_W-1:0] accel_y;
  logic signed [amlc_pkg::FIELD_W-1:0] accel_z;
  logic                                sample_valid;

  modport source (output valid, kind, accel_x, accel_y, accel_z, sample_valid,
                  input ready);
  modport sink (input valid, kind, accel_x, accel_y, accel_z, sample_valid,
                output ready);
endinterface

[src/amlc_out_if.sv]
// ----------------------------------------------------------------------------
// amlc_out_if: block result channel
// Valid/ready channel carrying the per-level minute counts of one block.
// ----------------------------------------------------------------------------
interface amlc_out_if;
  logic                              valid;
  logic                              ready;
  logic [amlc_pkg::COUNT_W-1:0]      sedentary_minutes;
  logic [amlc_pkg::COUNT_W-1:0]      light_minutes;
  logic [amlc_pkg::COUNT_W-1:0]      moderate_minutes;
  logic [amlc_pkg::COUNT_W-1:0]      vigorous_minutes;
  logic [amlc_pkg::INDEX_W-1:0]      block_start_sample;
  logic [amlc_pkg::COUNT_W-1:0]      block_minutes;

  modport source (output valid, sedentary_minutes, light_minutes, moderate_minutes,
                  vigorous_minutes, block_start_sample, block_minutes,
                  input ready);
  modport sink (input valid, sedentary_minutes, light_minutes, moderate_minutes,
                vigorous_minutes, block_start_sample, block_minutes,
                output ready);
endinterface

[src/amlc_sqrt.sv]
// ----------------------------------------------------------------------------
// amlc_sqrt: digit-serial integer square root
// Shifts the radicand out two bits per cycle and builds the root one bit per
// cycle; done is high for a single cycle, together with the last root digit.
// ----------------------------------------------------------------------------
module amlc_sqrt #(
  parameter int SB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*SB-1:0] radicand,
  output logic            done,
  output logic [SB-1:0]   root
);

  localparam int CNT_W = $clog2(SB + 1);

  logic [2*SB-1:0]  rad;
  logic [SB+1:0]    rem;
  logic [SB+1:0]    rem_shift;
  logic [SB+1:0]    trial;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             fits;

  assign rem_shift = {rem[SB-1:0], rad[2*SB-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = (rem_shift >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rad  <= '0;
      rem  <= '0;
      root <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(SB);
        busy <= 1'b1;
      end else if (busy) begin
        rad <= {rad[2*SB-3:0], 2'b00};
        if (fits) begin
          rem  <= rem_shift - trial;
          root <= {root[SB-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[SB-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/activity_minute_level_classifier.sv]
// Flow: a sample with sample_valid set passes the square state, which forms
//   the axis squares, and the root state, whose square root retires two radicand
//   bits a cycle; a sample without it is taken in idle alone. A closing minute
//   adds the classify and tally states, and the emit state loads a block result.
// Throughput: one transaction at a time; ready is high only while idle.
// Reset: synchronous; loads register defaults, clears all counters and sums.
// ----------------------------------------------------------------------------
// activity_minute_level_classifier: minute-level activity classifier
// Accumulates |magnitude - 1 g| per minute, classifies each minute against
// three cut points and emits per-level minute counts once per block.
// ----------------------------------------------------------------------------
module activity_minute_level_classifier #(
  parameter int LEVELS      = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  amlc_in_if.sink                         in_ch,
  amlc_out_if.source                      out_ch,
  input  logic                            cfg_write,
  input  logic [amlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [amlc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int MUL_W = (SB > 16) ? SB : 16;
  localparam int D_W   = (SB > 13) ? SB : 13;
  localparam int LVL_W = $clog2(LEVELS);
  localparam int NC    = (LEVELS - 1 < amlc_pkg::NUM_CUTS) ? LEVELS - 1 : amlc_pkg::NUM_CUTS;
  localparam int CW    = amlc_pkg::COUNT_W;

  // Configuration registers
  logic [amlc_pkg::PHASE_W-1:0] samples_per_minute;
  logic [CW-1:0]                minutes_per_block;
  logic [amlc_pkg::CUT_W-1:0]   cut_light;
  logic [amlc_pkg::CUT_W-1:0]   cut_moderate;
  logic [amlc_pkg::CUT_W-1:0]   cut_vigorous;

  // Running state
  amlc_pkg::state_t                state;
  amlc_pkg::state_t                state_next;
  logic [amlc_pkg::INDEX_W-1:0]    sample_index;
  logic [amlc_pkg::PHASE_W-1:0]    minute_phase;
  logic [amlc_pkg::SUM_W-1:0]      magnitude_sum;
  logic [amlc_pkg::VCOUNT_W-1:0]   valid_count;
  logic [CW-1:0]                   minute_count;
  logic [CW-1:0]                   level_minutes [LEVELS];
  logic [amlc_pkg::INDEX_W-1:0]    block_start;
  logic                            block_open;
  logic                            minute_end;

  // Per-sample working registers
  logic [SB-1:0]                   ax;
  logic [SB-1:0]                   ay;
  logic [SB-1:0]                   az;
  logic [2*SB-1:0]                 sq_acc;
  logic [2*MUL_W-1:0]              prod;
  logic [amlc_pkg::CUT_W-1:0]      cut_hold;
  logic [LVL_W-1:0]                lvl;
  logic [amlc_pkg::STEP_W-1:0]     step;

  // Result slot
  logic                            out_valid;
  logic [CW-1:0]                   out_sed;
  logic [CW-1:0]                   out_light;
  logic [CW-1:0]                   out_mod;
  logic [CW-1:0]                   out_vig;
  logic [amlc_pkg::INDEX_W-1:0]    out_start;
  logic [CW-1:0]                   out_blk;

  // Combinational helpers
  logic                            in_ready;
  logic                            in_fire;
  logic                            out_free;
  logic                            emit_load;
  logic                            root_start;
  logic                            root_done;
  logic [SB-1:0]                   root;
  logic [2*SB-1:0]                 radicand;
  logic [amlc_pkg::PHASE_W-1:0]    spm_eff;
  logic [CW-1:0]                   mpb_eff;
  logic [amlc_pkg::PHASE_W-1:0]    phase_inc;
  logic                            phase_end;
  logic [CW-1:0]                   mc_next;
  logic [SB-1:0]                   raw_sel;
  logic [SB-1:0]                   mag_sel;
  logic [amlc_pkg::CUT_W-1:0]      cut_sel;
  logic [MUL_W-1:0]                mul_a;
  logic [MUL_W-1:0]                mul_b;
  logic [D_W-1:0]                  root_ext;
  logic [D_W-1:0]                  dev;
  logic [amlc_pkg::SUM_W:0]        sum_wide;
  logic                            hit;
  logic [CW-1:0]                   lm_full [4];

  // Zero in either count register behaves as one.
  assign spm_eff   = (samples_per_minute == '0) ? amlc_pkg::PHASE_W'(1) : samples_per_minute;
  assign mpb_eff   = (minutes_per_block == '0) ? CW'(1) : minutes_per_block;
  assign phase_inc = minute_phase + amlc_pkg::PHASE_W'(1);
  assign phase_end = (phase_inc >= spm_eff);
  assign mc_next   = minute_count + CW'(1);

  assign in_fire  = in_ch.valid && in_ready;
  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = in_ready;

  // Sum of squares is complete once the third product lands.
  assign radicand = sq_acc + prod[2*SB-1:0];

  amlc_sqrt #(.SB(SB)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  // Deviation from 1 g and saturating accumulate
  assign root_ext = D_W'(root);
  assign dev = (root_ext >= D_W'(1 << amlc_pkg::FRAC_BITS))
             ? root_ext - D_W'(1 << amlc_pkg::FRAC_BITS)
             : D_W'(1 << amlc_pkg::FRAC_BITS) - root_ext;
  assign sum_wide = {1'b0, magnitude_sum} + (amlc_pkg::SUM_W + 1)'(dev);

  // An empty minute has mean zero: only a zero cut is met.
  assign hit = (valid_count == '0) ? (cut_hold == '0)
                                   : ((2*MUL_W)'(magnitude_sum) >= prod);

  // Shared multiplier operands: axis squares, then cut times valid count.
  always_comb begin
    unique case (step)
      2'd0:    raw_sel = ax;
      2'd1:    raw_sel = ay;
      default: raw_sel = az;
    endcase
    unique case (step)
      2'd0:    cut_sel = cut_light;
      2'd1:    cut_sel = cut_moderate;
      2'd2:    cut_sel = cut_vigorous;
      default: cut_sel = '0;
    endcase
    mag_sel = raw_sel[SB-1] ? (~raw_sel) + SB'(1) : raw_sel;
    if (state == amlc_pkg::ST_CLASSIFY) begin
      mul_a = MUL_W'(cut_sel);
      mul_b = MUL_W'(valid_count);
    end else begin
      mul_a = MUL_W'(mag_sel);
      mul_b = MUL_W'(mag_sel);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Counts for levels the block does not have read as zero.
  for (genvar j = 0; j < 4; j++) begin : g_lm
    if (j < LEVELS) begin : g_have
      assign lm_full[j] = level_minutes[j];
    end else begin : g_none
      assign lm_full[j] = '0;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amlc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    root_start = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      amlc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind) begin
            if (minute_count != '0) begin
              state_next = amlc_pkg::ST_EMIT;
            end
          end else if (in_ch.sample_valid) begin
            state_next = amlc_pkg::ST_SQUARE;
          end else if (phase_end) begin
            state_next = amlc_pkg::ST_CLASSIFY;
          end
        end
      end
      amlc_pkg::ST_SQUARE: begin
        if (step == 2'd3) begin
          root_start = 1'b1;
          state_next = amlc_pkg::ST_ROOT;
        end
      end
      amlc_pkg::ST_ROOT: begin
        if (root_done) begin
          state_next = minute_end ? amlc_pkg::ST_CLASSIFY : amlc_pkg::ST_IDLE;
        end
      end
      amlc_pkg::ST_CLASSIFY: begin
        if (step == amlc_pkg::STEP_W'(NC)) begin
          state_next = amlc_pkg::ST_TALLY;
        end
      end
      amlc_pkg::ST_TALLY: begin
        state_next = (mc_next >= mpb_eff) ? amlc_pkg::ST_EMIT : amlc_pkg::ST_IDLE;
      end
      amlc_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_load  = 1'b1;
          state_next = amlc_pkg::ST_IDLE;
        end
      end
      default: state_next = amlc_pkg::ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_minute <= amlc_pkg::RST_SAMPLES_PER_MINUTE;
      minutes_per_block  <= amlc_pkg::RST_MINUTES_PER_BLOCK;
      cut_light          <= amlc_pkg::RST_CUT_LIGHT;
      cut_moderate       <= amlc_pkg::RST_CUT_MODERATE;
      cut_vigorous       <= amlc_pkg::RST_CUT_VIGOROUS;
      sample_index       <= '0;
      minute_phase       <= '0;
      magnitude_sum      <= '0;
      valid_count        <= '0;
      minute_count       <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        level_minutes[i] <= '0;
      end
      block_start        <= '0;
      block_open         <= 1'b0;
      minute_end         <= 1'b0;
      step               <= '0;
      lvl                <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          amlc_pkg::REG_SAMPLES_PER_MINUTE: samples_per_minute <= cfg_data;
          amlc_pkg::REG_MINUTES_PER_BLOCK:  minutes_per_block  <= cfg_data[CW-1:0];
          amlc_pkg::REG_CUT_LIGHT:          cut_light          <= cfg_data;
          amlc_pkg::REG_CUT_MODERATE:       cut_moderate       <= cfg_data;
          amlc_pkg::REG_CUT_VIGOROUS:       cut_vigorous       <= cfg_data;
          default: ;
        endcase
      end

      // Load a new result; otherwise drop the held one once the consumer
      // takes it.
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        amlc_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.kind) begin
              // Flush with nothing complete: clear here; otherwise the
              // emit state snapshots and clears.
              if (minute_count == '0) begin
                minute_phase  <= '0;
                magnitude_sum <= '0;
                valid_count   <= '0;
                block_open    <= 1'b0;
                for (int i = 0; i < LEVELS; i++) begin
                  level_minutes[i] <= '0;
                end
              end
            end else begin
              if (!block_open) begin
                block_start <= sample_index;
                block_open  <= 1'b1;
              end
              sample_index <= sample_index + amlc_pkg::INDEX_W'(1);
              minute_phase <= phase_inc;
              minute_end   <= phase_end;
              step         <= '0;
              lvl          <= '0;
            end
          end
        end
        amlc_pkg::ST_SQUARE: begin
          step <= step + amlc_pkg::STEP_W'(1);
        end
        amlc_pkg::ST_ROOT: begin
          if (root_done) begin
            magnitude_sum <= sum_wide[amlc_pkg::SUM_W]
                           ? '1 : sum_wide[amlc_pkg::SUM_W-1:0];
            valid_count   <= valid_count + amlc_pkg::VCOUNT_W'(1);
            step          <= '0;
            lvl           <= '0;
          end
        end
        amlc_pkg::ST_CLASSIFY: begin
          step <= step + amlc_pkg::STEP_W'(1);
          // Ascending cuts: the last one met is the highest level.
          if (step != '0 && hit) begin
            lvl <= LVL_W'(step);
          end
        end
        amlc_pkg::ST_TALLY: begin
          level_minutes[lvl] <= level_minutes[lvl] + CW'(1);
          minute_count       <= mc_next;
          minute_phase       <= '0;
          magnitude_sum      <= '0;
          valid_count        <= '0;
        end
        amlc_pkg::ST_EMIT: begin
          if (emit_load) begin
            minute_count  <= '0;
            block_open    <= 1'b0;
            minute_phase  <= '0;
            magnitude_sum <= '0;
            valid_count   <= '0;
            for (int i = 0; i < LEVELS; i++) begin
              level_minutes[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Square accumulation and result payload hold no control state.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ax     <= SB'($unsigned(in_ch.accel_x));
      ay     <= SB'($unsigned(in_ch.accel_y));
      az     <= SB'($unsigned(in_ch.accel_z));
      sq_acc <= '0;
    end else if (state == amlc_pkg::ST_SQUARE && step != '0) begin
      sq_acc <= radicand;
    end
    if (state == amlc_pkg::ST_CLASSIFY) begin
      cut_hold <= cut_sel;
    end
    if (emit_load) begin
      out_sed   <= lm_full[0];
      out_light <= lm_full[1];
      out_mod   <= lm_full[2];
      out_vig   <= lm_full[3];
      out_start <= block_start;
      out_blk   <= minute_count;
    end
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.sedentary_minutes  = out_sed;
  assign out_ch.light_minutes      = out_light;
  assign out_ch.moderate_minutes   = out_mod;
  assign out_ch.vigorous_minutes   = out_vig;
  assign out_ch.block_start_sample = out_start;
  assign out_ch.block_minutes      = out_blk;

endmodule

[src/amlc_checker.sv]
// ----------------------------------------------------------------------------
// amlc_checker: port-level checks of the activity level classifier
// Watches the sample and result channels; attached by bind.
// ----------------------------------------------------------------------------
module amlc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_kind,
  input logic                         in_sample_valid,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [amlc_pkg::COUNT_W-1:0] sed,
  input logic [amlc_pkg::COUNT_W-1:0] light,
  input logic [amlc_pkg::COUNT_W-1:0] moder,
  input logic [amlc_pkg::COUNT_W-1:0] vig,
  input logic [amlc_pkg::COUNT_W-1:0] blk_min
);

  logic [amlc_pkg::COUNT_W-1:0] total;
  assign total = sed + light + moder + vig;

  // A counted sample always goes through the square root, so the block is busy.
  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !in_kind && in_sample_valid) |=> !in_ready)
    else $error("ready stayed high after a sample transaction");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(blk_min) && $stable(sed)))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total == blk_min && blk_min != '0))
    else $error("level counts disagree with block minutes");

endmodule

bind activity_minute_level_classifier amlc_checker u_amlc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .in_sample_valid (in_ch.sample_valid),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .sed             (out_ch.sedentary_minutes),
  .light           (out_ch.light_minutes),
  .moder           (out_ch.moderate_minutes),
  .vig             (out_ch.vigorous_minutes),
  .blk_min         (out_ch.block_minutes)
);
